/* rtl/core/assert_macros.svh */
// Assertion macros shared by the blur RTL.
// Depends on nothing; each file that checks itself includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/cgb_pkg.sv */
// Shared constants, types and codes of the cascaded 3x3 Gaussian blur.
// No dependencies; used by the interfaces, the blur pass and the top level.
`timescale 1ns / 1ps

package cgb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = NUM_CHAN * CHAN_W;

    // Configuration data is an 11-bit size field.
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 4;

    // Column counter holds the width itself, row counter runs two rows past the image.
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // Pipeline depth of one blur pass, from control in to result register.
    localparam int PASS_LAT = 3;

    // Result queue depth covers the whole item-to-result latency of both passes.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int FILL_W    = $clog2(OUT_DEPTH + 1);

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [PIX_W-1:0]  t_pix;   // red in the low byte, blue in the high byte

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // Per-item control for one pass; row gates zero the rows outside the image.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              top_ok;
        logic              mid_ok;
        logic              cur_ok;
        logic              edge_l;
        logic              edge_r;
        logic              emit;
        logic              last;
    } t_pass_ctl;

endpackage

/* rtl/core/cgb_if.sv */
// Handshake interfaces of the blur: pixel input, pixel output and configuration writes.
// Depends on cgb_pkg for the payload types.
`timescale 1ns / 1ps

interface cgb_pix_in_if;
    import cgb_pkg::*;

    logic  valid;
    logic  ready;
    t_op   operation;
    t_chan red_in;
    t_chan green_in;
    t_chan blue_in;

    modport source(output valid, operation, red_in, green_in, blue_in, input ready);
    modport sink(input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface cgb_pix_out_if;
    import cgb_pkg::*;

    logic  valid;
    logic  ready;
    t_chan red_out;
    t_chan green_out;
    t_chan blue_out;
    logic  last_pixel;

    modport source(output valid, red_out, green_out, blue_out, last_pixel, input ready);
    modport sink(input valid, red_out, green_out, blue_out, last_pixel, output ready);
endinterface

interface cgb_cfg_if;
    import cgb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/cgb_pass.sv */
// One 3x3 Gaussian pass over packed RGB: a two-row line memory and a 3x3 window.
// Depends on cgb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cgb_pass (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cgb_pkg::t_pass_ctl i_ctl,
    input  cgb_pkg::t_pix      i_pix,
    output logic               o_res_valid,
    output cgb_pkg::t_pix      o_res_pix,
    output logic               o_res_last
);
    import cgb_pkg::*;

    localparam int CS_W  = CHAN_W + 2;
    localparam int SUM_W = CHAN_W + 4;

    // One entry per column keeps the two rows above the current one.
    typedef struct packed {
        t_pix newer;
        t_pix older;
    } t_line;

    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix cur;
    } t_col;

    function automatic logic [CS_W-1:0] col_sum(input t_col c, input int ch);
        return CS_W'(c.top[ch*CHAN_W +: CHAN_W])
             + CS_W'({c.mid[ch*CHAN_W +: CHAN_W], 1'b0})
             + CS_W'(c.cur[ch*CHAN_W +: CHAN_W]);
    endfunction

    // Columns outside the image are dropped; the divide by 16 is the upper bits.
    function automatic t_chan chan_blur(input t_col c0, input t_col c1, input t_col c2,
                                        input logic skip_l, input logic skip_r,
                                        input int ch);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'({col_sum(c1, ch), 1'b0});
        if (!skip_l) sum = sum + SUM_W'(col_sum(c0, ch));
        if (!skip_r) sum = sum + SUM_W'(col_sum(c2, ch));
        return sum[SUM_W-1 -: CHAN_W];
    endfunction

    t_line     r_line_mem [MAX_WIDTH];
    t_line     r_rd;
    t_pass_ctl r_s1;
    t_pass_ctl r_s2;
    t_pix      r_s1_pix;
    t_col      r_win [3];
    t_col      s_col;
    t_pix      s_blur;

    always_comb begin
        s_col.top = r_s1.top_ok ? r_rd.older : '0;
        s_col.mid = r_s1.mid_ok ? r_rd.newer : '0;
        s_col.cur = r_s1.cur_ok ? r_s1_pix : '0;
    end

    // Read one cycle ahead, write back the shifted column when the item moves on.
    always_ff @(posedge i_clk) begin
        r_rd     <= r_line_mem[i_ctl.addr];
        r_s1_pix <= i_pix;
        if (r_s1.valid) begin
            r_line_mem[r_s1.addr] <= '{newer: s_col.cur, older: s_col.mid};
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= s_col;
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            s_blur[ch*CHAN_W +: CHAN_W] = chan_blur(r_win[0], r_win[1], r_win[2],
                                                    r_s2.edge_l, r_s2.edge_r, ch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            o_res_valid <= 1'b0;
        end else begin
            r_s1        <= i_ctl;
            r_s2        <= r_s1;
            o_res_valid <= r_s2.valid && r_s2.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res_pix  <= s_blur;
        o_res_last <= r_s2.last;
    end

    // A column is revisited only a full row later, so read and write never collide.
    `ASSERT_NEVER(a_rw_collision, i_clk, i_rst_n,
        r_s1.valid && i_ctl.valid && (r_s1.addr == i_ctl.addr),
        "line memory read and write hit the same column")
    `ASSERT_NEVER(a_edge_both, i_clk, i_rst_n,
        r_s2.valid && r_s2.edge_l && r_s2.edge_r,
        "output column is both left and right image edge")
    `ASSERT_PROP(a_res_timing, i_clk, i_rst_n,
        o_res_valid == $past(r_s2.valid && r_s2.emit),
        "pass result valid out of step with its window stage")

endmodule

/* rtl/core/cascaded_gaussian_blur_3x3_rgb.sv */
// Two cascaded 3x3 Gaussian blurs over an RGB raster stream.
// Depends on cgb_pkg, cgb_if, cgb_pass and assert_macros.svh.
//
// i_pix takes one item per clock: a pixel in raster order or a drain item that
// pads the stream after the image. o_pix returns the twice-blurred pixels in
// raster order; last_pixel marks the final pixel of the image, after which the
// block starts over with the next image. Output pixel n belongs to input item
// n + 2*width + 2, so the first 2*width + 2 items of an image return nothing.
// An item is accepted at a valid and ready edge; the pixel it completes then
// leaves through pass two and the queue. Throughput is one item per clock, set
// by the single read and write port of each line memory, used once per item.
// Results wait in an eight-entry queue; i_pix.ready drops only when eight
// results are owed to a stalled receiver, so a stall on o_pix backs up into
// i_pix after that. i_cfg writes image_width (index 0) or image_height
// (index 1); sizes below 3 act as 3 and above the maximum as the maximum, and
// a write restarts the image. Write only while the block is idle. Reset sets
// both sizes to 1024, empties the queue and restarts the image; line memories
// are not cleared and need no clearing time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cascaded_gaussian_blur_3x3_rgb (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cgb_cfg_if.sink        i_cfg,
    cgb_pix_in_if.sink     i_pix,
    cgb_pix_out_if.source  o_pix
);
    import cgb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam int                   MIN_DIM          = 3;
    localparam logic [DIM_W-1:0]     RESET_DIM        = DIM_W'(1024);

    typedef struct packed {
        logic last;
        t_pix pix;
    } t_out_item;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        if (int'(v) < MIN_DIM) return MIN_DIM;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Returns {top_ok, mid_ok, cur_ok}: which window rows lie inside the image.
    function automatic logic [2:0] row_gates(input logic [ROW_W-1:0] row,
                                             input logic [ROW_W-1:0] hgt);
        logic top_ok;
        logic mid_ok;
        logic cur_ok;
        top_ok = (row >= ROW_W'(2)) && ((row - ROW_W'(2)) < hgt);
        mid_ok = (row >= ROW_W'(1)) && ((row - ROW_W'(1)) < hgt);
        cur_ok = row < hgt;
        return {top_ok, mid_ok, cur_ok};
    endfunction

    logic [COL_W-1:0]     r_width;
    logic [ROW_W-1:0]     r_height;
    logic [COL_W-1:0]     r_col;
    logic [COL_W-1:0]     n_col;
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     n_row;

    logic                 s_acc;
    logic                 s_cfg_wr;
    logic                 s_act1;
    logic                 s_act2;
    logic                 s_emit1;
    logic                 s_emit2;
    logic                 s_last;
    logic [ROW_W-1:0]     s_oy;
    logic [ROW_W-1:0]     s_oy2;
    logic [COL_W-1:0]     s_ox;
    logic [COL_W-1:0]     s_ox2;
    logic [2:0]           s_gate1;
    logic [2:0]           s_gate2;
    t_pix                 s_pix_in;

    t_pass_ctl            s_ctl1;
    t_pass_ctl            s_ctl2;
    t_pass_ctl            r_d2 [PASS_LAT];

    logic                 s_p1_valid;
    logic                 s_p1_last;
    t_pix                 s_p1_pix;
    logic                 s_p2_valid;
    logic                 s_p2_last;
    t_pix                 s_p2_pix;

    t_out_item            r_fifo [OUT_DEPTH];
    t_out_item            s_head;
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    r_pending;
    logic                 s_pop;
    logic                 s_owe;

    assign i_cfg.ready = 1'b1;
    assign s_cfg_wr    = i_cfg.valid
                      && (i_cfg.index == REG_IMAGE_WIDTH || i_cfg.index == REG_IMAGE_HEIGHT);

    assign i_pix.ready = r_pending < FILL_W'(OUT_DEPTH);
    assign s_acc       = i_pix.valid && i_pix.ready;
    assign s_pix_in    = (i_pix.operation == OP_PIXEL)
                       ? {i_pix.blue_in, i_pix.green_in, i_pix.red_in} : '0;

    // Pass one centers on the position one row and one column behind the item;
    // pass two is fed at that position and centers one step further behind.
    always_comb begin
        s_act1  = (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && r_col != '0);
        s_oy    = (r_col == '0) ? r_row - ROW_W'(2) : r_row - ROW_W'(1);
        s_ox    = (r_col == '0) ? r_width - COL_W'(1) : r_col - COL_W'(1);
        s_emit1 = s_act1 && (s_oy < r_height);

        s_act2  = (s_oy >= ROW_W'(2)) || (s_oy == ROW_W'(1) && s_ox != '0);
        s_oy2   = (s_ox == '0) ? s_oy - ROW_W'(2) : s_oy - ROW_W'(1);
        s_ox2   = (s_ox == '0) ? r_width - COL_W'(1) : s_ox - COL_W'(1);
        s_emit2 = s_act1 && s_act2 && (s_oy2 < r_height);
        s_last  = s_emit2 && (s_oy2 == r_height - ROW_W'(1))
                          && (s_ox2 == r_width - COL_W'(1));

        s_gate1 = row_gates(r_row, r_height);
        s_gate2 = row_gates(s_oy, r_height);

        s_ctl1.valid  = s_acc;
        s_ctl1.addr   = r_col[ADDR_W-1:0];
        s_ctl1.top_ok = s_gate1[2];
        s_ctl1.mid_ok = s_gate1[1];
        s_ctl1.cur_ok = s_gate1[0];
        s_ctl1.edge_l = s_ox == '0;
        s_ctl1.edge_r = s_ox == r_width - COL_W'(1);
        s_ctl1.emit   = s_emit1;
        s_ctl1.last   = 1'b0;

        s_ctl2.valid  = s_acc && s_act1;
        s_ctl2.addr   = s_ox[ADDR_W-1:0];
        s_ctl2.top_ok = s_gate2[2];
        s_ctl2.mid_ok = s_gate2[1];
        s_ctl2.cur_ok = s_gate2[0];
        s_ctl2.edge_l = s_ox2 == '0;
        s_ctl2.edge_r = s_ox2 == r_width - COL_W'(1);
        s_ctl2.emit   = s_emit2;
        s_ctl2.last   = s_last;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (s_cfg_wr || (s_acc && s_last)) begin
            n_col = '0;
            n_row = '0;
        end else if (s_acc) begin
            if (r_col == r_width - COL_W'(1)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= COL_W'(clamp_dim(RESET_DIM, MAX_WIDTH));
            r_height <= ROW_W'(clamp_dim(RESET_DIM, MAX_HEIGHT));
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg.valid && i_cfg.index == REG_IMAGE_WIDTH) begin
                r_width <= COL_W'(clamp_dim(i_cfg.data, MAX_WIDTH));
            end
            if (i_cfg.valid && i_cfg.index == REG_IMAGE_HEIGHT) begin
                r_height <= ROW_W'(clamp_dim(i_cfg.data, MAX_HEIGHT));
            end
        end
    end

    cgb_pass u_pass1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s_ctl1),
        .i_pix       (s_pix_in),
        .o_res_valid (s_p1_valid),
        .o_res_pix   (s_p1_pix),
        .o_res_last  (s_p1_last)
    );

    // Pass two control waits for the first pass result of the same item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PASS_LAT; i++) begin
                r_d2[i] <= '0;
            end
        end else begin
            r_d2[0] <= s_ctl2;
            for (int i = 1; i < PASS_LAT; i++) begin
                r_d2[i] <= r_d2[i-1];
            end
        end
    end

    cgb_pass u_pass2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_d2[PASS_LAT-1]),
        .i_pix       (s_p1_pix),
        .o_res_valid (s_p2_valid),
        .o_res_pix   (s_p2_pix),
        .o_res_last  (s_p2_last)
    );

    // Result queue; r_pending counts results owed, both queued and in flight.
    assign s_pop = o_pix.valid && o_pix.ready;
    assign s_owe = s_acc && s_emit2;

    always_ff @(posedge i_clk) begin
        if (s_p2_valid) begin
            r_fifo[r_wr_ptr] <= '{last: s_p2_last, pix: s_p2_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_fill    <= '0;
            r_pending <= '0;
        end else begin
            if (s_p2_valid) begin
                r_wr_ptr <= (r_wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1))
                          ? '0 : r_wr_ptr + OUT_PTR_W'(1);
            end
            if (s_pop) begin
                r_rd_ptr <= (r_rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1))
                          ? '0 : r_rd_ptr + OUT_PTR_W'(1);
            end
            if (s_p2_valid && !s_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (!s_p2_valid && s_pop) begin
                r_fill <= r_fill - FILL_W'(1);
            end
            if (s_owe && !s_pop) begin
                r_pending <= r_pending + FILL_W'(1);
            end else if (!s_owe && s_pop) begin
                r_pending <= r_pending - FILL_W'(1);
            end
        end
    end

    assign s_head           = r_fifo[r_rd_ptr];
    assign o_pix.valid      = r_fill != '0;
    assign o_pix.red_out    = s_head.pix[0*CHAN_W +: CHAN_W];
    assign o_pix.green_out  = s_head.pix[1*CHAN_W +: CHAN_W];
    assign o_pix.blue_out   = s_head.pix[2*CHAN_W +: CHAN_W];
    assign o_pix.last_pixel = s_head.last;

    `ASSERT_NEVER(a_queue_overrun, i_clk, i_rst_n,
        s_p2_valid && !s_pop && (r_fill == FILL_W'(OUT_DEPTH)),
        "result queue written while full")
    `ASSERT_PROP(a_pass_align, i_clk, i_rst_n,
        (s_p1_valid && !s_p1_last)
            == (r_d2[PASS_LAT-1].valid && r_d2[PASS_LAT-1].cur_ok),
        "first pass result out of step with second pass control")
    `ASSERT_PROP(a_restart, i_clk, i_rst_n,
        (s_acc && s_last) |=> (r_col == '0 && r_row == '0),
        "image position not restarted after the last pixel")
    `ASSERT_PROP(a_col_range, i_clk, i_rst_n,
        r_col < r_width,
        "column position outside the image width")

endmodule

/* test/cgb_tb_pkg.sv */
// Register indexes and size clamping shared by the blur checker and the blur testbench.
// Depends on cgb_pkg for the field widths.
`timescale 1ns / 1ps

package cgb_tb_pkg;
    import cgb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1;
    // An index with no register behind it; a write there changes nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = '1;

    // Size actually in use for a raw register value.
    function automatic int unsigned dim_in_use(logic [DIM_W-1:0] raw, int unsigned hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return 32'(raw);
    endfunction
endpackage

/* test/cgb_blur_checker.sv */
// Checker for the cascaded blur: watches the configuration, pixel input and pixel output
// channels, predicts the twice-blurred pixels and compares them. Depends on cgb_pkg,
// cgb_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps

module cgb_blur_checker
    import cgb_pkg::*;
    import cgb_tb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    cgb_cfg_if     cfg_mon,
    cgb_pix_in_if  pix_in_mon,
    cgb_pix_out_if pix_out_mon,
    output int     o_fail_count,
    output int     o_pending
);

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        logic  last;
    } t_blurred;

    // Two rows per pass; index 0 is the first blur, index 1 the second.
    t_pix             line_store [2][2*MAX_WIDTH];
    t_pix             window     [2][9];
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_count;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    t_blurred         blurred_q [$];
    int               mismatches;

    function automatic void restart_image();
        for (int p = 0; p < 2; p++) begin
            for (int i = 0; i < 9; i++) window[p][i] = '0;
        end
        in_col    = 0;
        in_row    = 0;
        out_count = 0;
    endfunction

    // One blur pass fed with the stream position (sy, sx). The pixel it produces, if any,
    // lies one row and one column behind that position.
    function automatic bit blur_pass(input int p, input int unsigned sy, input int unsigned sx,
                                     input t_pix pix, input int unsigned w,
                                     input int unsigned h, output t_pix res);
        int unsigned slot, other, oy, ox, sum;
        t_pix        row_up2, row_up1, row_now;
        slot    = (sy & 1) * MAX_WIDTH + sx;
        other   = ((sy + 1) & 1) * MAX_WIDTH + sx;
        row_up2 = '0;
        row_up1 = '0;
        row_now = '0;
        res     = '0;
        if (sy >= 2 && sy - 2 < h) row_up2 = line_store[p][slot];
        if (sy >= 1 && sy - 1 < h) row_up1 = line_store[p][other];
        if (sy < h) begin
            row_now = pix;
            line_store[p][slot] = pix;
        end
        for (int r = 0; r < 3; r++) begin
            window[p][r*3]     = window[p][r*3 + 1];
            window[p][r*3 + 1] = window[p][r*3 + 2];
        end
        window[p][2] = row_up2;
        window[p][5] = row_up1;
        window[p][8] = row_now;

        if (sy == 0 || (sy == 1 && sx == 0)) return 1'b0;
        if (sx == 0) begin
            oy = sy - 2;
            ox = w - 1;
        end else begin
            oy = sy - 1;
            ox = sx - 1;
        end
        if (oy >= h) return 1'b0;

        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            sum = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    // Columns beyond the left or right image edge count as zero.
                    if (!(c == 0 && ox == 0) && !(c == 2 && ox == w - 1))
                        sum += ((r == 1) ? 2 : 1) * ((c == 1) ? 2 : 1)
                               * window[p][r*3 + c][CHAN_W*ch +: CHAN_W];
                end
            end
            res[CHAN_W*ch +: CHAN_W] = t_chan'(sum / 16);
        end
        return 1'b1;
    endfunction

    function automatic void predict_item(input t_op op, input t_chan r, input t_chan g,
                                         input t_chan b);
        int unsigned w, h, y2, x2;
        t_pix        pix, blur1, blur2;
        bit          have1, have2;
        w     = dim_in_use(width_reg, MAX_WIDTH);
        h     = dim_in_use(height_reg, MAX_HEIGHT);
        pix   = (op == OP_PIXEL) ? {b, g, r} : t_pix'(0);
        have1 = blur_pass(0, in_row, in_col, pix, w, h, blur1);
        have2 = 1'b0;
        if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
            if (in_col >= 1) begin
                y2 = in_row - 1;
                x2 = in_col - 1;
            end else begin
                y2 = in_row - 2;
                x2 = w - 1;
            end
            have2 = blur_pass(1, y2, x2, have1 ? blur1 : t_pix'(0), w, h, blur2);
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (have2) begin
            out_count++;
            blurred_q.push_back('{red: blur2[7:0], green: blur2[15:8], blue: blur2[23:16],
                                  last: (out_count >= w * h)});
            if (out_count >= w * h) restart_image();
        end
    endfunction

    always @(posedge i_clk) begin
        t_blurred want;
        if (!i_rst_n) begin
            width_reg  = DIM_W'(MAX_WIDTH);
            height_reg = DIM_W'(MAX_HEIGHT);
            restart_image();
            blurred_q.delete();
            mismatches = 0;
        end else begin
            if (pix_out_mon.valid && pix_out_mon.ready) begin
                if (blurred_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("blur check: pixel r=%0d g=%0d b=%0d last=%0b with none owed",
                                 pix_out_mon.red_out, pix_out_mon.green_out,
                                 pix_out_mon.blue_out, pix_out_mon.last_pixel);
                end else begin
                    want = blurred_q.pop_front();
                    if (pix_out_mon.red_out !== want.red || pix_out_mon.green_out !== want.green
                        || pix_out_mon.blue_out !== want.blue
                        || pix_out_mon.last_pixel !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("blur check: expected r=%0d g=%0d b=%0d last=%0b,",
                                     want.red, want.green, want.blue, want.last,
                                     " got r=%0d g=%0d b=%0d last=%0b",
                                     pix_out_mon.red_out, pix_out_mon.green_out,
                                     pix_out_mon.blue_out, pix_out_mon.last_pixel);
                    end
                end
            end
            if (cfg_mon.valid && cfg_mon.ready) begin
                if (cfg_mon.index == REG_WIDTH) begin
                    width_reg = cfg_mon.data;
                    restart_image();
                end else if (cfg_mon.index == REG_HEIGHT) begin
                    height_reg = cfg_mon.data;
                    restart_image();
                end
            end
            if (pix_in_mon.valid && pix_in_mon.ready)
                predict_item(pix_in_mon.operation, pix_in_mon.red_in, pix_in_mon.green_in,
                             pix_in_mon.blue_in);
        end
        o_fail_count <= mismatches;
        o_pending    <= blurred_q.size();
    end

endmodule

/* test/cascaded_gaussian_blur_3x3_rgb_tb.sv */
// Testbench top for the cascaded 3x3 blur: drives configuration writes and pixel items
// with random gaps and output stalls, and reports the checker's verdict.
// Depends on cgb_pkg, cgb_tb_pkg, the channel interfaces, cgb_blur_checker and the block.
`timescale 1ns / 1ps

module cascaded_gaussian_blur_3x3_rgb_tb;
    import cgb_pkg::*;
    import cgb_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PROBE_ITEMS   = 64;

    // Small image, {operation, blue, green, red}: three rows of three, then eight
    // padding items, some of them pixels whose channels must be ignored.
    localparam logic [24:0] SMALL_IMAGE [17] = '{
        {1'b0, 24'hFFFFFF}, {1'b0, 24'h000000}, {1'b0, 24'hAA00FF},
        {1'b1, 24'hFFFFFF}, {1'b0, 24'hFFFFFF}, {1'b0, 24'hFE8001},
        {1'b0, 24'hFFFFFF}, {1'b0, 24'h7F7F7F}, {1'b0, 24'h00FF00},
        {1'b0, 24'hFF55AA}, {1'b1, 24'h000000}, {1'b0, 24'h123456}, {1'b1, 24'hFFFFFF},
        {1'b0, 24'hFFFFFF}, {1'b0, 24'hFFFFFF}, {1'b1, 24'h000000}, {1'b0, 24'h808080}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    bit               steady;
    int               cycle_count = 0;
    int               fail_count;
    int               pending;
    int               items_sent = 0;
    logic [DIM_W-1:0] width_raw = DIM_W'(MAX_WIDTH);
    logic [DIM_W-1:0] height_raw = DIM_W'(MAX_HEIGHT);

    cgb_cfg_if     cfg_bus();
    cgb_pix_in_if  pix_in_bus();
    cgb_pix_out_if pix_out_bus();

    cascaded_gaussian_blur_3x3_rgb uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_in_bus),
        .o_pix   (pix_out_bus)
    );

    cgb_blur_checker blur_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_mon      (cfg_bus),
        .pix_in_mon   (pix_in_bus),
        .pix_out_mon  (pix_out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        pix_out_bus.ready <= steady || ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_chan rand_chan();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return t_chan'($urandom_range(255));
        endcase
    endfunction

    // Valid stays high from one item to the next unless a gap is taken, so it is never
    // lowered and raised within the same step.
    task automatic send_item(input t_op op, input t_chan r, input t_chan g, input t_chan b);
        while (!steady && $urandom_range(99) < 23) begin
            pix_in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in_bus.valid     <= 1'b1;
        pix_in_bus.operation <= op;
        pix_in_bus.red_in    <= r;
        pix_in_bus.green_in  <= g;
        pix_in_bus.blue_in   <= b;
        do @(posedge i_clk); while (!pix_in_bus.ready);
        items_sent++;
    endtask

    task automatic send_stream(input int unsigned count, input int drain_pct);
        for (int unsigned i = 0; i < count; i++)
            send_item(($urandom_range(99) < drain_pct) ? OP_DRAIN : OP_PIXEL,
                      rand_chan(), rand_chan(), rand_chan());
    endtask

    // Wait for every owed pixel, then let items that owe nothing leave the pipeline.
    task automatic hold_until_drained();
        pix_in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val,
                             input bit more);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (!more) cfg_bus.valid <= 1'b0;
        if (idx == REG_WIDTH) width_raw = val;
        else if (idx == REG_HEIGHT) height_raw = val;
    endtask

    task automatic set_size(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw);
        hold_until_drained();
        write_reg(REG_WIDTH, w_raw, 1'b1);
        write_reg(REG_HEIGHT, h_raw, 1'b0);
    endtask

    // A whole image plus its padding, or a random prefix of it when broken.
    task automatic run_image(input bit broken);
        int unsigned w, h, pixels, padding, cut;
        w       = dim_in_use(width_raw, MAX_WIDTH);
        h       = dim_in_use(height_raw, MAX_HEIGHT);
        pixels  = w * h;
        padding = 2 * w + 2;
        if (broken) begin
            send_stream($urandom_range(pixels + padding - 1, 1), 10);
            hold_until_drained();
        end else begin
            cut = $urandom_range(pixels - 1, 1);
            send_stream(cut, 8);
            if ($urandom_range(9) == 0) hold_until_drained();
            send_stream(pixels - cut, 8);
            send_stream(padding, 50);
        end
    endtask

    initial begin
        int               img;
        int               first_random;
        int               pick;
        bit               broken;
        logic [DIM_W-1:0] w_new, h_new;

        steady                 = 1'b0;
        i_rst_n               <= 1'b0;
        pix_in_bus.valid      <= 1'b0;
        pix_in_bus.operation  <= OP_PIXEL;
        pix_in_bus.red_in     <= '0;
        pix_in_bus.green_in   <= '0;
        pix_in_bus.blue_in    <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_WIDTH;
        cfg_bus.data          <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sizes from reset: a stream too short to reach the first output pixel.
        send_stream(PROBE_ITEMS, 5);

        // Sizes below three act as three.
        set_size(0, 1);
        for (int i = 0; i < 17; i++)
            send_item(t_op'(SMALL_IMAGE[i][24]), SMALL_IMAGE[i][7:0], SMALL_IMAGE[i][15:8],
                      SMALL_IMAGE[i][23:16]);

        // Pause mid-image until all owed pixels are out; a write to an index with no
        // register must leave the image running.
        set_size(4, 3);
        send_stream(7, 10);
        hold_until_drained();
        write_reg(REG_SPARE, '1, 1'b0);
        send_stream(15, 10);

        // A real register write mid-image starts the image over.
        set_size(5, 4);
        send_stream(13, 10);
        hold_until_drained();
        write_reg(REG_HEIGHT, 4, 1'b0);
        run_image(1'b0);

        // Sizes above the maximum act as the maximum; a short stream must show neither
        // an early output nor an early end of the image.
        set_size(2047, 2);
        send_stream(PROBE_ITEMS, 5);
        set_size(3, 2047);
        send_stream(PROBE_ITEMS, 5);

        img          = 0;
        first_random = items_sent;
        broken       = 1'b0;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            if (img == 0) begin
                set_size(16, 8);
                steady = 1'b1;
            end else begin
                steady = 1'b0;
                if (broken || $urandom_range(99) < 70) begin
                    hold_until_drained();
                    w_new = DIM_W'(($urandom_range(99) < 10) ? $urandom_range(2)
                          : (($urandom_range(99) < 6) ? $urandom_range(40, 11)
                                                       : $urandom_range(10, 3)));
                    h_new = DIM_W'(($urandom_range(99) < 15) ? $urandom_range(2)
                                                              : $urandom_range(6, 3));
                    pick = $urandom_range(9);
                    if (pick < 2) begin
                        write_reg(REG_WIDTH, w_new, 1'b0);
                    end else if (pick < 4) begin
                        write_reg(REG_HEIGHT, h_new, 1'b0);
                    end else begin
                        write_reg(REG_WIDTH, w_new, 1'b1);
                        write_reg(REG_HEIGHT, h_new, 1'b0);
                    end
                end
            end
            broken = (img != 0) && ($urandom_range(99) < 20);
            run_image(broken);
            img++;
        end
        steady = 1'b0;

        hold_until_drained();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
